>>> sv/point_polyline_distance_core_assert.svh
// assertion macros used by the checker file
`ifndef POINT_POLYLINE_DISTANCE_CORE_ASSERT_SVH
`define POINT_POLYLINE_DISTANCE_CORE_ASSERT_SVH

// property checked on every edge outside reset
`define PPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define PPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants of the point to polyline distance core.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DIST_BITS      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_TDEC,
    ST_DIV,
    ST_OFS,
    ST_DIST,
    ST_ROOT,
    ST_FIN
  } state_t;

endpackage

>>> sv/point_polyline_distance_core.sv
// ----------------------------------------------------------------------------
// point_polyline_distance_core
// Minimum distance from a query point to a polyline, one vertex per request.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carries one vertex with the query point
// and the first_vertex / last_vertex marks. The query point is latched when a
// polyline opens. Output channel: out_valid / out_stall carries one result
// (distance, no_segment) after each last vertex.
// A vertex that opens a polyline is taken in idle. Every later vertex runs a
// shared multiplier and a small sequencer: 4 products, a decision step,
// FRAC_BITS restoring divide steps, 2 offset products, 2 square products,
// one square root step per root bit (COORD_BITS+3, or FRAC_BITS+2 if
// larger) and a finish step; the divide is skipped when the fraction needs
// no divide, and the next request is taken once the sequencer is back in
// idle. in_stall stays high while a vertex is in work, and a last vertex
// is held off while an earlier result still sits in the output register.
// A result waits in the output register for as long as out_stall is high.
// Reset empties the sequencer and the output register and closes any
// open polyline.
// ----------------------------------------------------------------------------
module point_polyline_distance_core #(
  parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ppd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      vertex_x,
  input  logic signed [COORD_BITS-1:0]      vertex_z,
  input  logic signed [COORD_BITS-1:0]      query_x,
  input  logic signed [COORD_BITS-1:0]      query_z,
  input  logic                              first_vertex,
  input  logic                              last_vertex,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ppd_pkg::DIST_BITS-1:0]     distance,
  output logic                              no_segment
);
  import ppd_pkg::*;

  localparam int E  = COORD_BITS + 1;
  localparam int MW = (COORD_BITS + 3 > FRAC_BITS + 2) ? COORD_BITS + 3 : FRAC_BITS + 2;
  localparam int AW = 2 * MW;
  localparam int TW = FRAC_BITS + 1;
  localparam int CW = $clog2(((MW > TW) ? MW : TW) + 1);
  localparam int XW = (MW > DIST_BITS) ? MW : DIST_BITS;

  state_t state, state_next;
  logic [CW-1:0] cnt;

  logic signed [COORD_BITS-1:0] prev_x, prev_z, held_query_x, held_query_z;
  logic [DIST_BITS-1:0] best_distance;
  logic [1:0] vertices_seen;
  logic last_pend;

  logic signed [E-1:0]  ex, ez, rx, rz;
  logic signed [AW-1:0] len2, dot;
  logic [AW-1:0]        rem;
  logic [TW-1:0]        t;
  logic signed [MW-1:0] dx, dz;
  logic [AW-1:0]        sq;
  logic [MW+1:0]        rrem;
  logic [MW-1:0]        root;

  logic                 accept, start, hold_fin;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] prod;
  logic signed [MW-1:0] offset;
  logic [AW-1:0]        rem_sh;
  logic [MW+3:0]        cand, trial;
  logic [XW-1:0]        root_ext;
  logic [DIST_BITS-1:0] d_sat, best_new;

  assign accept   = in_valid && !in_stall;
  assign start    = first_vertex || (vertices_seen == 2'd0);
  assign hold_fin = last_pend && out_valid && out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && !start) state_next = ST_DOT;
      ST_DOT:  if (cnt == CW'(3)) state_next = ST_TDEC;
      ST_TDEC: begin
        if (len2 == '0 || dot <= 0 || dot >= len2) state_next = ST_OFS;
        else state_next = ST_DIV;
      end
      ST_DIV:  if (cnt == '0) state_next = ST_OFS;
      ST_OFS:  if (cnt == CW'(1)) state_next = ST_DIST;
      ST_DIST: if (cnt == CW'(1)) state_next = ST_ROOT;
      ST_ROOT: if (cnt == '0) state_next = ST_FIN;
      ST_FIN:  if (!hold_fin) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = (state != ST_IDLE) || (out_valid && last_vertex);
  end

  // shared multiplier operand select and datapath helpers
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DOT: begin
        case (cnt)
          CW'(0):  begin mul_a = MW'(ex); mul_b = MW'(ex); end
          CW'(1):  begin mul_a = MW'(ez); mul_b = MW'(ez); end
          CW'(2):  begin mul_a = MW'(rx); mul_b = MW'(ex); end
          default: begin mul_a = MW'(rz); mul_b = MW'(ez); end
        endcase
      end
      ST_OFS: begin
        mul_a = (cnt == '0) ? MW'(ex) : MW'(ez);
        mul_b = MW'({1'b0, t});
      end
      ST_DIST: begin
        mul_a = (cnt == '0) ? dx : dz;
        mul_b = (cnt == '0) ? dx : dz;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod   = mul_a * mul_b;
    // arithmetic shift floors toward minus infinity
    offset = MW'(prod >>> FRAC_BITS);
    rem_sh = {rem[AW-2:0], 1'b0};
    cand   = {rrem, sq[AW-1:AW-2]};
    trial  = (MW+4)'({root, 2'b01});
    root_ext = XW'(root);
    d_sat  = (root_ext > XW'({DIST_BITS{1'b1}})) ? '1 : root_ext[DIST_BITS-1:0];
    best_new = (d_sat < best_distance) ? d_sat : best_distance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      vertices_seen <= 2'd0;
      best_distance <= '1;
      out_valid     <= 1'b0;
      last_pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        case (state_next)
          ST_DIV:  cnt <= CW'(FRAC_BITS - 1);
          ST_ROOT: cnt <= CW'(MW - 1);
          default: cnt <= '0;
        endcase
      end else if (state == ST_DIV || state == ST_ROOT) begin
        cnt <= cnt - CW'(1);
      end else begin
        cnt <= cnt + CW'(1);
      end

      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_x <= vertex_x;
            prev_z <= vertex_z;
            if (start) begin
              held_query_x <= query_x;
              held_query_z <= query_z;
              if (last_vertex) begin
                out_valid     <= 1'b1;
                distance      <= '1;
                no_segment    <= 1'b1;
                vertices_seen <= 2'd0;
              end else begin
                vertices_seen <= 2'd1;
              end
              best_distance <= '1;
            end else begin
              ex <= E'(vertex_x) - E'(prev_x);
              ez <= E'(vertex_z) - E'(prev_z);
              rx <= E'(held_query_x) - E'(prev_x);
              rz <= E'(held_query_z) - E'(prev_z);
              last_pend <= last_vertex;
            end
          end
        end
        ST_DOT: begin
          case (cnt)
            CW'(0):  len2 <= prod;
            CW'(1):  len2 <= len2 + prod;
            CW'(2):  dot  <= prod;
            default: dot  <= dot + prod;
          endcase
        end
        ST_TDEC: begin
          t   <= '0;
          rem <= dot;
          if (len2 != '0 && dot > 0 && dot >= len2) t <= TW'(1) << FRAC_BITS;
        end
        ST_DIV: begin
          // one restoring divide step per cycle
          if (rem_sh >= len2) begin
            rem <= rem_sh - len2;
            t   <= {t[TW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            t   <= {t[TW-2:0], 1'b0};
          end
        end
        ST_OFS: begin
          if (cnt == '0) dx <= MW'(rx) - offset;
          else dz <= MW'(rz) - offset;
        end
        ST_DIST: begin
          if (cnt == '0) begin
            sq <= prod;
          end else begin
            sq   <= sq + prod;
            rrem <= '0;
            root <= '0;
          end
        end
        ST_ROOT: begin
          // two radicand bits per step, one root bit out
          if (cand >= trial) begin
            rrem <= (MW+2)'(cand - trial);
            root <= {root[MW-2:0], 1'b1};
          end else begin
            rrem <= (MW+2)'(cand);
            root <= {root[MW-2:0], 1'b0};
          end
          sq <= {sq[AW-3:0], 2'b00};
        end
        ST_FIN: begin
          if (!hold_fin) begin
            if (last_pend) begin
              out_valid     <= 1'b1;
              distance      <= best_new;
              no_segment    <= 1'b0;
              vertices_seen <= 2'd0;
              best_distance <= '1;
            end else begin
              vertices_seen <= 2'd2;
              best_distance <= best_new;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/ppd_checker.sv
// ----------------------------------------------------------------------------
// ppd_checker
// Port level checks of the point to polyline distance core, bound to the top.
// ----------------------------------------------------------------------------
`include "point_polyline_distance_core_assert.svh"

module ppd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          first_vertex,
  input logic                          last_vertex,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ppd_pkg::DIST_BITS-1:0] distance,
  input logic                          no_segment
);
  import ppd_pkg::*;

  `PPD_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(distance) && $stable(no_segment), "stalled result changed")
  `PPD_ASSERT(a_noseg_max, clk, rst, out_valid && no_segment |-> distance == {DIST_BITS{1'b1}}, "no segment result not saturated")
  `PPD_ASSERT(a_single_vertex, clk, rst, in_valid && !in_stall && first_vertex && last_vertex |=> out_valid && no_segment, "one vertex request gave no flagged result")
  `PPD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result after reset")

endmodule

bind point_polyline_distance_core ppd_checker u_ppd_checker (.*);

>>> bench/point_polyline_distance_core_tb.sv
// ----------------------------------------------------------------------------
// point_polyline_distance_core_tb
// Self-checking bench for the point to polyline distance core: directed
// polylines cover the corner cases, then random polylines run under several
// idle and stall patterns. Every result is checked against a local model.
// ----------------------------------------------------------------------------
module point_polyline_distance_core_tb;

  localparam int CB = ppd_pkg::COORD_BITS_DEF;

  typedef struct packed {
    logic [ppd_pkg::DIST_BITS-1:0] dist_val;
    logic                          noseg;
  } dist_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [CB-1:0] vertex_x, vertex_z, query_x, query_z;
  logic first_vertex, last_vertex;
  logic out_valid;
  logic out_stall;
  logic [ppd_pkg::DIST_BITS-1:0] distance;
  logic no_segment;

  dist_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct;
  int stall_pct;

  // model state
  logic signed [CB-1:0] m_prev_x, m_prev_z, m_qx, m_qz;
  logic [31:0] m_best;
  int m_seen;

  point_polyline_distance_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_x(vertex_x), .vertex_z(vertex_z),
    .query_x(query_x), .query_z(query_z),
    .first_vertex(first_vertex), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .no_segment(no_segment)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] int_sqrt(logic [127:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 62; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= v) root = cand;
    end
    return root;
  endfunction

  function automatic logic [31:0] segment_dist(logic signed [CB-1:0] ax, az, bx, bz, qx, qz);
    logic signed [127:0] ex, ez, rx, rz, len2, dot, t, dx, dz;
    logic [63:0] root;
    ex = 128'(bx) - 128'(ax);
    ez = 128'(bz) - 128'(az);
    rx = 128'(qx) - 128'(ax);
    rz = 128'(qz) - 128'(az);
    len2 = ex * ex + ez * ez;
    dot = rx * ex + rz * ez;
    if (len2 == 0 || dot <= 0) t = 0;
    else if (dot >= len2) t = 128'sd1 <<< ppd_pkg::FRAC_BITS_DEF;
    else t = (dot <<< ppd_pkg::FRAC_BITS_DEF) / len2;
    // arithmetic shift floors toward minus infinity
    dx = rx - ((ex * t) >>> ppd_pkg::FRAC_BITS_DEF);
    dz = rz - ((ez * t) >>> ppd_pkg::FRAC_BITS_DEF);
    root = int_sqrt(dx * dx + dz * dz);
    return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
  endfunction

  task automatic model_reset();
    m_prev_x = '0; m_prev_z = '0; m_qx = '0; m_qz = '0;
    m_best = '1;
    m_seen = 0;
  endtask

  task automatic predict_vertex(logic signed [CB-1:0] vx, vz, qx, qz, logic fst, lst);
    logic [31:0] d;
    dist_result_t r;
    if (fst || m_seen == 0) begin
      m_qx = qx; m_qz = qz;
      m_best = '1;
      m_seen = 1;
    end else begin
      d = segment_dist(m_prev_x, m_prev_z, vx, vz, m_qx, m_qz);
      if (d < m_best) m_best = d;
      m_seen = 2;
    end
    m_prev_x = vx; m_prev_z = vz;
    if (lst) begin
      r.dist_val = (m_seen < 2) ? 32'hFFFF_FFFF : m_best;
      r.noseg = (m_seen < 2);
      pending_results.push_back(r);
      m_seen = 0;
      m_best = '1;
    end
  endtask

  task automatic send_vertex(logic signed [CB-1:0] vx, vz, qx, qz, logic fst, lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_x <= vx; vertex_z <= vz;
    query_x <= qx; query_z <= qz;
    first_vertex <= fst; last_vertex <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertex(vx, vz, qx, qz, fst, lst);
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    dist_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result dist=%h noseg=%b", distance, no_segment);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.dist_val !== distance || exp_r.noseg !== no_segment) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected dist=%h noseg=%b, got dist=%h noseg=%b",
                     exp_r.dist_val, exp_r.noseg, distance, no_segment);
        end
      end
    end
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2 * 65536 * 40)) - 65536 * 40;
      2: return $signed($urandom_range(2000)) - 1000;
      default: return ($urandom_range(1)) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                          : 32'sh8000_0000 + $urandom_range(3);
    endcase
  endfunction

  task automatic test_directed();
    localparam logic signed [CB-1:0] MAXC = 32'sh7FFF_FFFF;
    localparam logic signed [CB-1:0] MINC = 32'sh8000_0000;
    localparam logic signed [CB-1:0] ONE  = 32'sh0001_0000;
    // open without first mark straight after reset, single vertex
    send_vertex(ONE, ONE, 0, 0, 1'b0, 1'b1);
    // one vertex marked both first and last
    send_vertex(0, 0, ONE, ONE, 1'b1, 1'b1);
    // zero-length segment
    send_vertex(5 * ONE, 0, 0, 0, 1'b1, 1'b0);
    send_vertex(5 * ONE, 0, 0, 0, 1'b0, 1'b1);
    // interior projection, then projections before the segment start
    send_vertex(-4 * ONE, 0, 0, 3 * ONE, 1'b1, 1'b0);
    send_vertex(4 * ONE, 0, 0, 0, 1'b0, 1'b0);
    send_vertex(9 * ONE, 7, 0, 0, 1'b0, 1'b1);
    send_vertex(0, 0, -3 * ONE + 5, -ONE, 1'b1, 1'b0);
    send_vertex(ONE, ONE, 0, 0, 1'b0, 1'b1);
    // first mark inside an open polyline drops it
    send_vertex(0, 0, ONE, 0, 1'b1, 1'b0);
    send_vertex(ONE, 0, 0, 0, 1'b0, 1'b0);
    send_vertex(ONE, ONE, 3, MAXC, 1'b1, 1'b0);
    send_vertex(MAXC, MAXC, 0, 0, 1'b0, 1'b1);
    // extremes, saturated distance
    send_vertex(MAXC, MAXC, MINC, MINC, 1'b1, 1'b0);
    send_vertex(MAXC, MAXC - 1, 0, 0, 1'b0, 1'b1);
    send_vertex(MINC, MAXC, MAXC, MINC, 1'b1, 1'b0);
    send_vertex(MAXC, MINC, 0, 0, 1'b0, 1'b1);
    send_vertex(MINC, MINC, -1, -1, 1'b1, 1'b0);
    send_vertex(-1, -1, 0, 0, 1'b0, 1'b1);
  endtask

  task automatic test_random(int n_items, int idle_pct, int st_pct);
    int sent;
    int nverts;
    logic signed [CB-1:0] qx, qz;
    send_idle_pct = idle_pct;
    stall_pct = st_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        nverts = ($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2);
        qx = rand_coord(); qz = rand_coord();
        for (int i = 0; i < nverts; i++)
          send_vertex(rand_coord(), rand_coord(), qx, qz, i == 0, i == nverts - 1);
        sent += nverts;
      end else begin
        // noise: random marks, including broken polylines
        send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    vertex_x = '0; vertex_z = '0; query_x = '0; query_z = '0;
    first_vertex = 1'b0; last_vertex = 1'b0;
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(290, 0, 0);
    test_random(280, 82, 0);
    test_random(280, 0, 82);
    test_random(280, 35, 35);
    // close any open polyline so its result drains
    send_vertex(0, 0, 0, 0, 1'b0, 1'b1);
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[point_polyline_distance_core] OK");
    else $display("[point_polyline_distance_core] ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[point_polyline_distance_core] ERROR");
    $finish;
  end

endmodule

>>> point_polyline_distance_core.f
+incdir+sv
sv/ppd_pkg.sv
sv/point_polyline_distance_core.sv
sv/ppd_checker.sv
bench/point_polyline_distance_core_tb.sv
